[hw/rtl/iir_direct_form_one_filter_defines.svh]
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter_defines
// Assertion macros used by the checker of the IIR filter block.
// Each macro checks one implication on the rising clock edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IIR_DIRECT_FORM_ONE_FILTER_DEFINES_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_DEFINES_SVH

// Same-cycle implication.
`define IIRDF1_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iirdf1 assertion failed");

// Next-cycle implication.
`define IIRDF1_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iirdf1 assertion failed");

`endif

[hw/rtl/iirdf1_pkg.sv]
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Widths, codes, control types and the round-and-saturate function of the
// direct form I IIR filter.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

    localparam int MAX_ORDER  = 4;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 24;
    localparam int COEF_FRAC  = COEF_W - 5;
    localparam int COEF_SLOTS = 2 * MAX_ORDER + 1;
    localparam int SLOT_W     = 4;
    localparam int HIST_IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int POLE_W     = 3;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + $clog2(COEF_SLOTS + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COEF_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLE_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_GAIN = 1'b1;

    // Item actions
    localparam logic ACT_FILTER = 1'b0;
    localparam logic ACT_WRITE  = 1'b1;

    localparam logic [POLE_W-1:0] POLE_RESET = POLE_W'(2);
    localparam logic signed [COEF_W-1:0] GAIN_RESET = COEF_W'(524288);

    localparam logic signed [ACC_W:0] ROUND_BIAS = (ACC_W + 1)'(1) << (COEF_FRAC - 1);
    localparam logic signed [ACC_W:0] SAT_HI = (ACC_W + 1)'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [ACC_W:0] SAT_LO = (ACC_W + 1)'(-(2 ** (SAMPLE_W - 1)));

    typedef struct packed {
        logic mul_en;
        logic acc_clear;
    } mac_ctrl_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       clip;
    } round_t;

    function automatic round_t round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] biased;
        logic signed [ACC_W:0] shifted;
        round_t                r;
        biased  = (ACC_W + 1)'(acc) + ROUND_BIAS;
        shifted = biased >>> COEF_FRAC;
        r.clip  = 1'b0;
        if (shifted > SAT_HI)
        begin
            r.value = SAT_HI[SAMPLE_W-1:0];
            r.clip  = 1'b1;
        end
        else if (shifted < SAT_LO)
        begin
            r.value = SAT_LO[SAMPLE_W-1:0];
            r.clip  = 1'b1;
        end
        else
        begin
            r.value = shifted[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/iirdf1_mac.sv]
// ----------------------------------------------------------------------------
// iirdf1_mac
// Shared multiply-accumulate unit: one registered product per cycle, added
// into the accumulator on the following cycle.
// ----------------------------------------------------------------------------
module iirdf1_mac
    import iirdf1_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctrl_t                ctrl,
    input  logic signed [SAMPLE_W-1:0] mul_a,
    input  logic signed [COEF_W-1:0]   mul_b,
    output logic signed [ACC_W-1:0]    acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign acc_next  = (ctrl.acc_clear ? ACC_W'(0) : acc_reg)
                     + (prod_valid_reg ? ACC_W'(prod_reg) : ACC_W'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

[hw/rtl/iir_direct_form_one_filter.sv]
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter
// Direct form I IIR filter of order 1..MAX_ORDER on one shared MAC unit.
// Each sample beat passes the states scale, MAC, drain, round and output,
// using the order clamped at acceptance; the MAC takes one product per cycle.
// No new beat is taken until the result of a sample beat has been taken,
// so output stalls hold off input. Reset: coefficients and histories zero,
// order 2, inverse gain 1.0, no result pending.
// ----------------------------------------------------------------------------
module iir_direct_form_one_filter
    import iirdf1_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       action,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [SLOT_W-1:0]          coef_index,
    input  logic signed [COEF_W-1:0]   coef_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       saturated
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE_MUL,
        S_SCALE_ACC,
        S_SCALE_RND,
        S_MAC,
        S_DRAIN,
        S_RND,
        S_OUT
    } state_t;

    state_t                     state_reg;
    logic [POLE_W-1:0]          pole_count_reg;
    logic signed [COEF_W-1:0]   inverse_gain_reg;
    logic signed [COEF_W-1:0]   coef_reg [COEF_SLOTS];
    logic signed [SAMPLE_W-1:0] in_hist_reg [MAX_ORDER];
    logic signed [SAMPLE_W-1:0] out_hist_reg [MAX_ORDER];
    logic [POLE_W-1:0]          n_reg;
    logic [SLOT_W-1:0]          t_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] xs_reg;
    logic                       clip_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       saturated_reg;
    logic                       out_valid_reg;

    logic                       in_accept;
    logic [POLE_W-1:0]          order_eff;
    logic [SLOT_W-1:0]          n_slot;
    logic [SLOT_W-1:0]          last_slot;
    logic [SLOT_W-1:0]          fb_idx;
    logic [SLOT_W-1:0]          ff_idx;
    logic signed [SAMPLE_W-1:0] tap_data;
    mac_ctrl_t                  mac_ctrl;
    logic signed [SAMPLE_W-1:0] mul_a;
    logic signed [COEF_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]    acc;
    round_t                     rnd;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Clamp the order to 1..MAX_ORDER
    always_comb
    begin
        if (pole_count_reg == '0)
            order_eff = POLE_W'(1);
        else if (pole_count_reg > POLE_W'(MAX_ORDER))
            order_eff = POLE_W'(MAX_ORDER);
        else
            order_eff = pole_count_reg;
    end

    // Slot t: feedback taps first, then feed-forward, current scaled input last
    assign n_slot    = SLOT_W'(n_reg);
    assign last_slot = n_slot << 1;
    assign fb_idx    = n_slot - SLOT_W'(1) - t_reg;
    assign ff_idx    = last_slot - SLOT_W'(1) - t_reg;

    always_comb
    begin
        if (t_reg < n_slot)
            tap_data = out_hist_reg[fb_idx[HIST_IDX_W-1:0]];
        else if (t_reg < last_slot)
            tap_data = in_hist_reg[ff_idx[HIST_IDX_W-1:0]];
        else
            tap_data = xs_reg;
    end

    always_comb
    begin
        mac_ctrl.mul_en    = 1'b0;
        mac_ctrl.acc_clear = 1'b0;
        mul_a              = tap_data;
        mul_b              = coef_reg[t_reg];
        case (state_reg)
            S_SCALE_MUL:
            begin
                mac_ctrl.mul_en    = 1'b1;
                mac_ctrl.acc_clear = 1'b1;
                mul_a              = sample_reg;
                mul_b              = inverse_gain_reg;
            end
            S_SCALE_RND:
            begin
                mac_ctrl.acc_clear = 1'b1;
            end
            S_MAC:
            begin
                mac_ctrl.mul_en = 1'b1;
            end
            default:
            begin
                mac_ctrl.mul_en = 1'b0;
            end
        endcase
    end

    iirdf1_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .acc   (acc)
    );

    assign rnd = round_sat(acc);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_count_reg   <= POLE_RESET;
            inverse_gain_reg <= GAIN_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_POLE_COUNT:   pole_count_reg   <= cfg_data[POLE_W-1:0];
                CFG_INVERSE_GAIN: inverse_gain_reg <= cfg_data[COEF_W-1:0];
                default:          pole_count_reg   <= pole_count_reg;
            endcase
        end
    end

    // Coefficient table; drop writes beyond the last slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_SLOTS; i++)
                coef_reg[i] <= '0;
        end
        else if (in_accept && action == ACT_WRITE && coef_index < SLOT_W'(COEF_SLOTS))
        begin
            coef_reg[coef_index] <= coef_value;
        end
    end

    // Delay lines advance once per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ORDER; i++)
            begin
                in_hist_reg[i]  <= '0;
                out_hist_reg[i] <= '0;
            end
        end
        else if (state_reg == S_RND)
        begin
            for (int i = MAX_ORDER - 1; i > 0; i--)
            begin
                in_hist_reg[i]  <= in_hist_reg[i-1];
                out_hist_reg[i] <= out_hist_reg[i-1];
            end
            in_hist_reg[0]  <= xs_reg;
            out_hist_reg[0] <= rnd.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            n_reg          <= '0;
            t_reg          <= '0;
            sample_reg     <= '0;
            xs_reg         <= '0;
            clip_reg       <= 1'b0;
            sample_out_reg <= '0;
            saturated_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && action == ACT_FILTER)
                    begin
                        sample_reg <= sample_in;
                        n_reg      <= order_eff;
                        state_reg  <= S_SCALE_MUL;
                    end
                end
                S_SCALE_MUL:
                begin
                    state_reg <= S_SCALE_ACC;
                end
                S_SCALE_ACC:
                begin
                    state_reg <= S_SCALE_RND;
                end
                S_SCALE_RND:
                begin
                    xs_reg    <= rnd.value;
                    clip_reg  <= rnd.clip;
                    t_reg     <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    t_reg <= t_reg + SLOT_W'(1);
                    if (t_reg == last_slot)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    sample_out_reg <= rnd.value;
                    saturated_reg  <= clip_reg | rnd.clip;
                    out_valid_reg  <= 1'b1;
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign saturated  = saturated_reg;

endmodule

[hw/rtl/iirdf1_checker.sv]
// ----------------------------------------------------------------------------
// iirdf1_checker
// Port-level checks of the IIR filter: result hold, busy while working,
// coefficient writes leaving the block idle.
// ----------------------------------------------------------------------------
`include "iir_direct_form_one_filter_defines.svh"

module iirdf1_checker
    import iirdf1_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       action,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [SAMPLE_W-1:0] sample_out,
    input logic                       saturated
);

    // Hold a stalled result
    `IIRDF1_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(sample_out) && $stable(saturated))

    // A sample beat keeps the block busy with no result yet
    `IIRDF1_ASSERT_NEXT(a_sample_busy, clk, rst_n, in_valid && !in_stall && action == ACT_FILTER, in_stall && !out_valid)

    // A coefficient write leaves the block idle with no result
    `IIRDF1_ASSERT_NEXT(a_write_idle, clk, rst_n, in_valid && !in_stall && action == ACT_WRITE, !in_stall && !out_valid)

    // No new beat while a result waits
    `IIRDF1_ASSERT_IMPLIES(a_stall_on_result, clk, rst_n, out_valid, in_stall)

endmodule

bind iir_direct_form_one_filter iirdf1_checker u_iirdf1_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .saturated  (saturated)
);

[tb/sv/iir_output_checker.sv]
// ----------------------------------------------------------------------------
// iir_output_checker
// Watches the register port and both beat channels of the IIR filter, keeps
// its own copy of the order, gain, coefficient table and delay lines, predicts
// each output sample and compares it field by field with what the block emits.
// ----------------------------------------------------------------------------
module iir_output_checker
    import iirdf1_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       action,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [SLOT_W-1:0]          coef_index,
    input  logic signed [COEF_W-1:0]   coef_value,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [SAMPLE_W-1:0] sample_out,
    input  logic                       saturated,
    output int                         fail_count,
    output int                         pending_results,
    output int                         results_checked,
    output int                         clipped_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clip;
    } filter_result_t;

    localparam longint SAMPLE_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
    localparam longint HALF_LSB  = longint'(1) << (COEF_FRAC - 1);

    logic [POLE_W-1:0]          order_reg;
    logic signed [COEF_W-1:0]   gain_reg;
    logic signed [COEF_W-1:0]   taps [COEF_SLOTS];
    logic signed [SAMPLE_W-1:0] x_hist [MAX_ORDER];
    logic signed [SAMPLE_W-1:0] y_hist [MAX_ORDER];
    filter_result_t             expected_outputs [$];
    int                         mismatches;
    int                         checked;
    int                         clipped;

    // Round half up from Q.34 down to Q1.15 and clip to the sample range.
    function automatic filter_result_t round_clip(input longint acc);
        longint         r;
        filter_result_t res;
        r = (acc + HALF_LSB) >>> COEF_FRAC;
        res.clip = 1'b0;
        if (r > SAMPLE_HI)
        begin
            res.sample = SAMPLE_W'(SAMPLE_HI);
            res.clip   = 1'b1;
        end
        else if (r < SAMPLE_LO)
        begin
            res.sample = SAMPLE_W'(SAMPLE_LO);
            res.clip   = 1'b1;
        end
        else
        begin
            res.sample = r[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    function automatic filter_result_t filter_sample(input logic signed [SAMPLE_W-1:0] x);
        int             n;
        int             d;
        longint         acc;
        filter_result_t xs;
        filter_result_t y;
        n = order_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_ORDER)
            n = MAX_ORDER;
        xs  = round_clip(longint'(x) * longint'(gain_reg));
        // slot 2n weights the current input, slot 2n-d the input d beats back,
        // slot n-d the output d beats back
        acc = longint'(xs.sample) * longint'(taps[2 * n]);
        for (d = 1; d <= n; d++)
        begin
            acc += longint'(x_hist[d - 1]) * longint'(taps[2 * n - d]);
            acc += longint'(y_hist[d - 1]) * longint'(taps[n - d]);
        end
        y = round_clip(acc);
        y.clip = y.clip | xs.clip;
        for (d = MAX_ORDER - 1; d > 0; d--)
        begin
            x_hist[d] = x_hist[d - 1];
            y_hist[d] = y_hist[d - 1];
        end
        x_hist[0] = xs.sample;
        y_hist[0] = y.sample;
        return y;
    endfunction

    initial
    begin
        mismatches = 0;
        checked    = 0;
        clipped    = 0;
        fail_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        filter_result_t exp_res;
        if (!rst_n)
        begin
            order_reg = POLE_RESET;
            gain_reg  = GAIN_RESET;
            foreach (taps[i])
                taps[i] = '0;
            foreach (x_hist[i])
            begin
                x_hist[i] = '0;
                y_hist[i] = '0;
            end
            expected_outputs.delete();
            pending_results <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_outputs.size() == 0)
                begin
                    $error("unexpected output beat: sample_out %0d saturated %0b",
                           sample_out, saturated);
                    mismatches++;
                end
                else
                begin
                    exp_res = expected_outputs.pop_front();
                    checked++;
                    if (exp_res.clip)
                        clipped++;
                    if (sample_out !== exp_res.sample)
                    begin
                        $error("sample_out: expected %0d, got %0d", exp_res.sample, sample_out);
                        mismatches++;
                    end
                    if (saturated !== exp_res.clip)
                    begin
                        $error("saturated: expected %0b, got %0b", exp_res.clip, saturated);
                        mismatches++;
                    end
                end
            end
            if (cfg_write_en)
            begin
                if (cfg_index == CFG_POLE_COUNT)
                    order_reg = cfg_data[POLE_W-1:0];
                else if (cfg_index == CFG_INVERSE_GAIN)
                    gain_reg = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                if (action == ACT_WRITE)
                begin
                    // slots past the table are dropped
                    if (coef_index < COEF_SLOTS)
                        taps[coef_index] = coef_value;
                end
                else
                begin
                    expected_outputs.push_back(filter_sample(sample_in));
                end
            end
            pending_results <= expected_outputs.size();
            fail_count      <= mismatches;
            results_checked <= checked;
            clipped_results <= clipped;
        end
    end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the direct form I IIR filter with a short directed sequence and then
// phases of random sample and coefficient beats under changing order and gain
// settings, with bursty input, random output stalls and one long output
// hold-off. The output checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import iirdf1_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES          = 12;
    localparam int BEATS_PER_PHASE = 90;
    localparam int PRESSURE_PHASE  = 9;
    localparam int PRESSURE_BEATS  = 60;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 2 * MAX_ORDER + 12;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [CFG_DATA_W-1:0]      cfg_data     = '0;
    logic                       in_valid     = 1'b0;
    logic                       in_stall;
    logic                       action       = ACT_FILTER;
    logic signed [SAMPLE_W-1:0] sample_in    = '0;
    logic [SLOT_W-1:0]          coef_index   = '0;
    logic signed [COEF_W-1:0]   coef_value   = '0;
    logic                       out_valid;
    logic                       out_stall    = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;

    int fail_count;
    int pending_results;
    int results_checked;
    int clipped_results;

    int sample_beats      = 0;
    int write_beats       = 0;
    int settings_run      = 0;
    int hold_off_requests = 0;
    int hold_offs_done    = 0;
    int idle_cycles       = 0;

    iir_direct_form_one_filter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .sample_in    (sample_in),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out),
        .saturated    (saturated)
    );

    iir_output_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .sample_in       (sample_in),
        .coef_index      (coef_index),
        .coef_value      (coef_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sample_out      (sample_out),
        .saturated       (saturated),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .clipped_results (clipped_results)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Output side: stall styles in random stretches, plus long hold-offs on request.
    initial
    begin
        int stall_style;
        int stretch_left;
        int hold_left;
        stall_style  = 0;
        stretch_left = 0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_offs_done != hold_off_requests)
            begin
                out_stall <= 1'b1;
                hold_left = HOLD_OFF_CYCLES - 1;
                hold_offs_done++;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stall_style  = $urandom_range(0, 3);
                    stretch_left = $urandom_range(10, 80);
                end
                stretch_left--;
                case (stall_style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 7) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[iir_direct_form_one_filter] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one beat and hold it until the block takes it.
    task automatic offer_beat(input logic act, input logic signed [SAMPLE_W-1:0] x,
                              input logic [SLOT_W-1:0] slot,
                              input logic signed [COEF_W-1:0] value);
        in_valid   <= 1'b1;
        action     <= act;
        sample_in  <= x;
        coef_index <= slot;
        coef_value <= value;
        do
            @(posedge clk);
        while (in_stall);
        if (act == ACT_WRITE)
            write_beats++;
        else
            sample_beats++;
    endtask

    // Drop valid, wait for every result, then let the pipeline drain.
    task automatic drain_filter();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [COEF_W-1:0] pick_coef(input bit wide_coefs);
        if (wide_coefs)
            return COEF_W'($urandom);
        // within +-0.25 so that even order four stays stable
        return COEF_W'(int'($urandom_range(0, 262143)) - 131072);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 19))
            0: return SAMPLE_W'(32767);
            1: return SAMPLE_W'(-32768);
            2: return '0;
            3, 4, 5: return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic random_beat(input bit wide_coefs);
        logic [SLOT_W-1:0] slot;
        if ($urandom_range(0, 99) < 12)
        begin
            if ($urandom_range(0, 19) < 17)
                slot = SLOT_W'($urandom_range(0, COEF_SLOTS - 1));
            else
                slot = SLOT_W'($urandom_range(COEF_SLOTS, 2 ** SLOT_W - 1));
            offer_beat(ACT_WRITE, SAMPLE_W'($urandom), slot, pick_coef(wide_coefs));
        end
        else
        begin
            offer_beat(ACT_FILTER, pick_sample(), SLOT_W'($urandom), COEF_W'($urandom));
        end
    endtask

    task automatic directed_beats();
        // zero table, then a pure pass-through on the current input
        offer_beat(ACT_FILTER, '0, '0, '0);
        offer_beat(ACT_FILTER, SAMPLE_W'(32767), '0, '0);
        offer_beat(ACT_FILTER, SAMPLE_W'(-32768), '0, '0);
        offer_beat(ACT_WRITE, '0, SLOT_W'(4), COEF_W'(524288));
        offer_beat(ACT_FILTER, SAMPLE_W'(32767), '0, '0);
        offer_beat(ACT_FILTER, SAMPLE_W'(-32768), '0, '0);
        offer_beat(ACT_FILTER, SAMPLE_W'(1), '0, '0);
        offer_beat(ACT_FILTER, SAMPLE_W'(-1), '0, '0);
        // writes past the table must leave it untouched
        offer_beat(ACT_WRITE, '0, SLOT_W'(COEF_SLOTS), COEF_W'(-1));
        offer_beat(ACT_WRITE, '0, SLOT_W'(15), COEF_W'(8388607));
        offer_beat(ACT_FILTER, SAMPLE_W'(100), '0, '0);
        // extreme feed-forward taps drive the output into both rails
        offer_beat(ACT_WRITE, '0, SLOT_W'(3), COEF_W'(8388607));
        offer_beat(ACT_WRITE, '0, SLOT_W'(2), COEF_W'(-8388608));
        offer_beat(ACT_FILTER, SAMPLE_W'(32767), '0, '0);
        offer_beat(ACT_FILTER, SAMPLE_W'(-32768), '0, '0);
        offer_beat(ACT_FILTER, '0, '0, '0);
        // extreme feedback taps: clipped outputs recirculate
        offer_beat(ACT_WRITE, '0, SLOT_W'(0), COEF_W'(-8388608));
        offer_beat(ACT_WRITE, '0, SLOT_W'(1), COEF_W'(8388607));
        offer_beat(ACT_FILTER, SAMPLE_W'(12345), '0, '0);
        offer_beat(ACT_FILTER, SAMPLE_W'(-12345), '0, '0);
        offer_beat(ACT_FILTER, '0, '0, '0);
    endtask

    initial
    begin
        int                      phase;
        int                      beat;
        int                      burst_left;
        bit                      wide_coefs;
        logic [POLE_W-1:0]       order_sel;
        logic [CFG_DATA_W-1:0]   gain_sel;
        int                      order_plan [PHASES];

        order_plan = '{1, 4, 3, 2, 0, 7, 4, 5, 1, 6, 3, 2};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_beats();
        drain_filter();
        settings_run = 1;

        for (phase = 0; phase < PHASES; phase++)
        begin
            order_sel = POLE_W'(order_plan[phase]);
            case (phase)
                0, 1, 10: gain_sel = CFG_DATA_W'(524288);
                2: gain_sel = CFG_DATA_W'(8388607);
                3: gain_sel = CFG_DATA_W'(-8388608);
                4: gain_sel = CFG_DATA_W'(262144);
                6: gain_sel = '0;
                7: gain_sel = CFG_DATA_W'(-524288);
                default: gain_sel = CFG_DATA_W'($urandom);
            endcase
            wide_coefs = (phase == 4 || phase == 6 || phase == 8 || phase == 10);

            // upper bits of the order word are don't-care; exercise them anyway
            write_register(CFG_POLE_COUNT,
                           {(CFG_DATA_W - POLE_W)'($urandom), order_sel});
            write_register(CFG_INVERSE_GAIN, gain_sel);
            settings_run++;

            // load a fresh table, then stream
            for (beat = 0; beat < COEF_SLOTS; beat++)
                offer_beat(ACT_WRITE, SAMPLE_W'($urandom), SLOT_W'(beat), pick_coef(wide_coefs));

            if (phase == PRESSURE_PHASE)
                hold_off_requests++;
            burst_left = $urandom_range(1, 24);
            for (beat = 0; beat < BEATS_PER_PHASE; beat++)
            begin
                if (burst_left == 0 && !(phase == PRESSURE_PHASE && beat < PRESSURE_BEATS))
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                    burst_left = $urandom_range(1, 24);
                end
                random_beat(wide_coefs);
                if (burst_left > 0)
                    burst_left--;
            end
            drain_filter();
        end

        $display("Run covered %0d sample beats and %0d coefficient writes under %0d settings",
                 sample_beats, write_beats, settings_run);
        $display("of order and gain; %0d outputs compared, %0d of them clipped.",
                 results_checked, clipped_results);
        if (fail_count == 0 && pending_results == 0)
            $display("[iir_direct_form_one_filter] OK");
        else
            $display("[iir_direct_form_one_filter] ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/iirdf1_pkg.sv
hw/rtl/iirdf1_mac.sv
hw/rtl/iir_direct_form_one_filter.sv
hw/rtl/iirdf1_checker.sv
tb/sv/iir_output_checker.sv
tb/sv/testbench.sv
